/* hdl/spt_pkg.sv */
package spt_pkg;

  localparam int PATH_DEPTH_DEF = 1024;

  localparam int CORDIC_W     = 54;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_PI_Q16   = 205887;
  localparam int PI_Q12       = 12868;
  localparam int TURN_SCALE   = 100000;

  localparam logic [2:0] CFG_GAIN_K         = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED      = 3'd1;
  localparam logic [2:0] CFG_RATE_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_ADVANCE_RADIUS = 3'd3;
  localparam logic [2:0] CFG_STALE_LIMIT    = 3'd4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POSE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_SQRT,
    ST_DST,
    ST_GM,
    ST_GS,
    ST_CW,
    ST_STEER,
    ST_SM,
    ST_DIV,
    ST_OUT
  } spt_state_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } spt_cordic_res_t;

  // atan(2^-n) in units of 2^-16 rad
  function automatic logic [16:0] atan_tab(input logic [3:0] n);
    logic [16:0] v;
    case (n)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

  // exp(-6 * 2^b / 4096) in Q0.16
  function automatic logic [15:0] expn_tab(input logic [3:0] b);
    logic [15:0] v;
    case (b)
      4'd0:    v = 16'd65440;
      4'd1:    v = 16'd65344;
      4'd2:    v = 16'd65153;
      4'd3:    v = 16'd64772;
      4'd4:    v = 16'd64018;
      4'd5:    v = 16'd62535;
      4'd6:    v = 16'd59671;
      4'd7:    v = 16'd54331;
      4'd8:    v = 16'd45042;
      4'd9:    v = 16'd30957;
      4'd10:   v = 16'd14623;
      4'd11:   v = 16'd3263;
      4'd12:   v = 16'd162;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/stanley_path_tracking_step.sv */
// Stanley path tracker. An item with tuser low stores a waypoint and the block stays
// ready. An item with tuser high is a pose; the block then stays busy through waypoint
// reads, cross product and squared distance on one shared 34x34 multiplier, a 32-step
// square root, distance and gain product, a 16-step CORDIC for the correction angle,
// steer and scale, then a 35-step divider that runs alongside the speed decay, which
// uses the same multiplier, and a last state to load the result. The segment heading
// CORDIC runs under the square root. A pose that is stale, arrives with no path or sits
// at the path end finishes with no result. A finished result waits in the output
// register while the block takes further items; a second result waits in the last
// state, with the block not ready, until the first has been handed over.
module stanley_path_tracking_step import spt_pkg::*; #(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // waypoint_index[9:0], pos_x[41:10], pos_y[73:42], heading[88:74], time_us[120:89]
  input  logic [127:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // turn_rate[15:0], speed[27:16], segment[37:28]
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

  spt_state_t state_r, state_nxt;

  logic [15:0] gain_k_r;
  logic [11:0] max_speed_r;
  logic [14:0] rate_limit_r;
  logic [30:0] advance_radius_r;
  logic [31:0] stale_limit_r;

  logic [10:0] path_length_r;
  logic        path_ready_r;
  logic [9:0]  segment_index_r;
  logic [31:0] last_time_r;

  logic [9:0]         in_slot;
  logic signed [31:0] in_px, in_py;
  logic signed [14:0] in_head;
  logic [31:0]        in_time;
  logic               in_acc, wp_we;
  logic [31:0]        dt_now;
  logic [10:0]        seg_inc;
  logic               pose_ok;

  logic [9:0]         seg_r;
  logic signed [31:0] px_r, py_r;
  logic signed [14:0] head_r;
  logic [31:0]        dt_r;
  logic signed [31:0] x0_r, y0_r;
  logic signed [32:0] dx_r, dy_r, rx_r, ry_r, ex_r, ey_r;
  logic [31:0]        mx_r, my_r;
  logic               big_r;
  logic               side_pos_r, side_neg_r;
  logic signed [67:0] p_r, pa_r;
  logic signed [68:0] cross_diff;
  logic [63:0]        sqv_r, sqres_r, sqbit_r, sq_trial;
  logic [4:0]         sqcnt_r;
  logic [32:0]        dist_r;
  logic signed [16:0] herr_r;
  logic [16:0]        herr_mag;
  logic signed [17:0] steer_r;
  logic [34:0]        q_r;
  logic [31:0]        rem_r;
  logic [32:0]        rem_s;
  logic               rem_ge;
  logic [5:0]         dcnt_r;
  logic               neg_r;
  logic [67:0]        p_mag;
  logic [27:0]        acc_r;
  logic [3:0]         eb_r;
  logic               eph_r, edone_r, ego_r;
  logic [13:0]        aerr_r;
  logic [14:0]        turn_lim;
  logic [15:0]        turn_val;
  logic [28:0]        speed_rnd;
  logic [39:0]        out_data_r;
  logic               out_valid_r;

  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_x, rd_y;
  logic signed [33:0] mul_a, mul_b;
  logic               cord_start;
  logic signed [CORDIC_W-1:0] cord_y, cord_x;
  spt_cordic_res_t    cord_res;

  assign in_slot   = in_tdata[9:0];
  assign in_px     = in_tdata[41:10];
  assign in_py     = in_tdata[73:42];
  assign in_head   = in_tdata[88:74];
  assign in_time   = in_tdata[120:89];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wp_we     = in_acc && (in_tuser == MODE_LOAD) &&
                     ({7'd0, in_slot} < 17'(PATH_DEPTH));
  assign dt_now    = in_time - last_time_r;
  assign seg_inc   = {1'b0, segment_index_r} + 11'd1;
  assign pose_ok   = path_ready_r && (dt_now <= stale_limit_r) &&
                     (seg_inc < path_length_r) && ({6'd0, seg_inc} < 17'(PATH_DEPTH));

  spt_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (wp_we),
    .waddr (AW'(in_slot)),
    .wdata (in_px),
    .raddr (rd_addr),
    .rdata (rd_x)
  );

  spt_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (wp_we),
    .waddr (AW'(in_slot)),
    .wdata (in_py),
    .raddr (rd_addr),
    .rdata (rd_y)
  );

  spt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .res   (cord_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == MODE_POSE && pose_ok) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_C0;
      ST_C0:    state_nxt = ST_C1;
      ST_C1:    state_nxt = ST_C2;
      ST_C2:    state_nxt = ST_C3;
      ST_C3:    state_nxt = ST_C4;
      ST_C4:    state_nxt = ST_SQRT;
      ST_SQRT:  if (sqcnt_r == 5'd0) state_nxt = ST_DST;
      ST_DST:   state_nxt = ST_GM;
      ST_GM:    state_nxt = ST_GS;
      ST_GS:    state_nxt = ST_CW;
      ST_CW:    if (cord_res.done) state_nxt = ST_STEER;
      ST_STEER: state_nxt = ST_SM;
      ST_SM:    state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 6'd0 && edone_r) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_addr    = AW'(seg_r);
    mul_a      = '0;
    mul_b      = '0;
    cord_start = 1'b0;
    cord_y     = CORDIC_W'(dy_r);
    cord_x     = CORDIC_W'(dx_r);
    case (state_r)
      ST_RD1: rd_addr = AW'({1'b0, seg_r} + 11'd1);
      ST_C0: begin
        mul_a      = 34'(dx_r);
        mul_b      = 34'(ry_r);
        cord_start = 1'b1;
      end
      ST_C1: begin
        mul_a = 34'(dy_r);
        mul_b = 34'(rx_r);
      end
      ST_C2: begin
        mul_a = {2'b00, mx_r};
        mul_b = {2'b00, mx_r};
      end
      ST_C3: begin
        mul_a = {2'b00, my_r};
        mul_b = {2'b00, my_r};
      end
      ST_GM: begin
        mul_a = {18'd0, gain_k_r};
        mul_b = {1'b0, dist_r};
      end
      ST_GS: begin
        cord_start = 1'b1;
        cord_y     = p_r[CORDIC_W-1:0];
        cord_x     = CORDIC_W'(64'd1 << 24);
      end
      ST_STEER: begin
        mul_a = 34'(steer_r);
        mul_b = 34'(TURN_SCALE);
      end
      ST_DIV: begin
        mul_a = {6'd0, acc_r};
        mul_b = {18'd0, expn_tab(eb_r)};
      end
      default: ;
    endcase
  end

  assign cross_diff = 69'(pa_r) - 69'(p_r);
  assign sq_trial   = sqres_r + sqbit_r;
  assign herr_mag   = herr_r[16] ? 17'(-herr_r) : 17'(herr_r);
  assign p_mag      = p_r[67] ? 68'(-p_r) : 68'(p_r);
  assign rem_s      = {rem_r, q_r[34]};
  assign rem_ge     = rem_s >= {1'b0, dt_r};
  assign turn_lim   = (q_r > {20'd0, rate_limit_r}) ? rate_limit_r : q_r[14:0];
  assign turn_val   = neg_r ? -{1'b0, turn_lim} : {1'b0, turn_lim};
  assign speed_rnd  = ego_r ? ({1'b0, acc_r} + 29'd32768) : 29'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      gain_k_r         <= 16'd256;
      max_speed_r      <= 12'd819;
      rate_limit_r     <= 15'd8192;
      advance_radius_r <= 31'd32768;
      stale_limit_r    <= 32'd1000000;
      path_length_r    <= '0;
      path_ready_r     <= 1'b0;
      segment_index_r  <= '0;
      last_time_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_K:         gain_k_r         <= cfg_wdata[15:0];
          CFG_MAX_SPEED:      max_speed_r      <= cfg_wdata[11:0];
          CFG_RATE_LIMIT:     rate_limit_r     <= cfg_wdata[14:0];
          CFG_ADVANCE_RADIUS: advance_radius_r <= cfg_wdata[30:0];
          CFG_STALE_LIMIT:    stale_limit_r    <= cfg_wdata;
          default: ;
        endcase
      end

      if (wp_we) begin
        path_length_r <= {1'b0, in_slot} + 11'd1;
        path_ready_r  <= 1'b1;
      end
      if (in_acc && in_tuser == MODE_POSE) begin
        last_time_r <= in_time;
      end

      // advance when the distance to the far waypoint is below the advance radius
      if (state_r == ST_GM && dist_r < {2'b00, advance_radius_r}) begin
        segment_index_r <= 10'({1'b0, seg_r} + 11'd1);
      end

      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        seg_r  <= segment_index_r;
        px_r   <= in_px;
        py_r   <= in_py;
        head_r <= in_head;
        dt_r   <= dt_now;
      end
      ST_RD1: begin
        x0_r <= rd_x;
        y0_r <= rd_y;
        rx_r <= 33'(px_r) - 33'($signed(rd_x));
        ry_r <= 33'(py_r) - 33'($signed(rd_y));
      end
      ST_RD2: begin
        dx_r <= 33'($signed(rd_x)) - 33'(x0_r);
        dy_r <= 33'($signed(rd_y)) - 33'(y0_r);
        ex_r <= 33'($signed(rd_x)) - 33'(px_r);
        ey_r <= 33'($signed(rd_y)) - 33'(py_r);
      end
      ST_C0: begin
        // halve both offsets when either is too wide to square exactly
        if ((ex_r[32] ? 33'(-ex_r) : ex_r) >= 33'h080000000 ||
            (ey_r[32] ? 33'(-ey_r) : ey_r) >= 33'h080000000) begin
          big_r <= 1'b1;
          mx_r  <= 32'((ex_r[32] ? 33'(-ex_r) : ex_r) >> 1);
          my_r  <= 32'((ey_r[32] ? 33'(-ey_r) : ey_r) >> 1);
        end else begin
          big_r <= 1'b0;
          mx_r  <= ex_r[32] ? 32'(-ex_r) : ex_r[31:0];
          my_r  <= ey_r[32] ? 32'(-ey_r) : ey_r[31:0];
        end
      end
      ST_C1: pa_r <= p_r;
      ST_C2: begin
        side_pos_r <= !cross_diff[68] && (cross_diff != '0);
        side_neg_r <= cross_diff[68];
      end
      ST_C3: pa_r <= p_r;
      ST_C4: begin
        sqv_r   <= 64'(pa_r) + 64'(p_r);
        sqres_r <= '0;
        sqbit_r <= 64'd1 << 62;
        sqcnt_r <= 5'd31;
      end
      ST_SQRT: begin
        if (sqv_r >= sq_trial) begin
          sqv_r   <= sqv_r - sq_trial;
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
        sqcnt_r <= sqcnt_r - 5'd1;
      end
      ST_DST: begin
        dist_r <= big_r ? {sqres_r[31:0], 1'b0} : {1'b0, sqres_r[31:0]};
        herr_r <= 17'(cord_res.angle) - 17'(head_r);
      end
      ST_CW: begin
        if (side_pos_r) begin
          steer_r <= 18'(herr_r) - 18'(cord_res.angle);
        end else if (side_neg_r) begin
          steer_r <= 18'(herr_r) + 18'(cord_res.angle);
        end else begin
          steer_r <= 18'(herr_r);
        end
      end
      ST_SM: begin
        neg_r   <= p_r[67];
        rem_r   <= '0;
        acc_r   <= {max_speed_r, 16'd0};
        eb_r    <= '0;
        eph_r   <= 1'b0;
        ego_r   <= herr_mag < 17'(PI_Q12);
        aerr_r  <= herr_mag[13:0];
        edone_r <= herr_mag >= 17'(PI_Q12);
        if (dt_r == '0) begin
          // saturate by the steer sign
          q_r    <= (steer_r != '0) ? '1 : '0;
          dcnt_r <= '0;
        end else begin
          q_r    <= p_mag[34:0];
          dcnt_r <= 6'd35;
        end
      end
      ST_DIV: begin
        if (dcnt_r != '0) begin
          rem_r  <= rem_ge ? 32'(rem_s - {1'b0, dt_r}) : rem_s[31:0];
          q_r    <= {q_r[33:0], rem_ge};
          dcnt_r <= dcnt_r - 6'd1;
        end
        if (!edone_r) begin
          eph_r <= !eph_r;
          if (eph_r) begin
            if (aerr_r[eb_r]) begin
              acc_r <= 28'((p_r + 68'sd32768) >>> 16);
            end
            eb_r <= eb_r + 4'd1;
            if (eb_r == 4'd13) edone_r <= 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {2'b00, seg_r, speed_rnd[27:16], turn_val};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_OUT))
    else $error("result appeared without a finished pose");

  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata[27:16] <= max_speed_r)
    else $error("speed above max_speed");

  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      ($signed(out_tdata[15:0]) <= $signed({1'b0, rate_limit_r})) &&
      ($signed(out_tdata[15:0]) >= -$signed({1'b0, rate_limit_r})))
    else $error("turn rate outside clamp");

  a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
    path_ready_r |-> path_length_r != '0)
    else $error("path ready with empty path");

endmodule

/* hdl/spt_ram.sv */
module spt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/spt_cordic.sv */
module spt_cordic import spt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  logic signed [CORDIC_W-1:0] x_in,
  output spt_cordic_res_t            res
);

  logic signed [CORDIC_W-1:0] x_r, y_r, xs, ys;
  logic signed [20:0]         z_r;
  logic [3:0]                 n_r;
  logic                       run_r, fin_r, done_r;
  logic signed [15:0]         ang_r;
  logic [20:0]                zmag;
  logic [16:0]                zrnd;

  assign xs = x_r >>> n_r;
  assign ys = y_r >>> n_r;

  assign zmag = z_r[20] ? 21'(-z_r) : 21'(z_r);
  assign zrnd = 17'((zmag + 21'd8) >> 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (x_in == '0 && y_in == '0) begin
          run_r  <= 1'b0;
          z_r    <= '0;
          fin_r  <= 1'b1;
        end else begin
          run_r <= 1'b1;
          n_r   <= '0;
          if (x_in < 0) begin
            x_r <= -x_in;
            y_r <= -y_in;
            z_r <= (y_in >= 0) ? 21'(ANG_PI_Q16) : -21'(ANG_PI_Q16);
          end else begin
            x_r <= x_in;
            y_r <= y_in;
            z_r <= '0;
          end
        end
      end else if (run_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + 21'(atan_tab(n_r));
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - 21'(atan_tab(n_r));
        end
        n_r <= n_r + 4'd1;
        if (n_r == 4'(CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r <= 1'b1;
        ang_r  <= z_r[20] ? -16'(zrnd) : 16'(zrnd);
      end
    end
  end

  assign res.done  = done_r;
  assign res.angle = ang_r;

endmodule

/* tb/sv/tb.sv */
module tb;
  import spt_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [9:0]  slot;
    logic [31:0] px;
    logic [31:0] py;
    logic [14:0] head;
    logic [31:0] tus;
  } pose_item_t;

  // first member in the top bits: segment, speed, turn_rate
  typedef struct packed {
    logic [9:0]  seg;
    logic [11:0] spd;
    logic [15:0] turn;
  } steer_cmd_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  stanley_path_tracking_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [31:0] wp_x [0:1023];
  logic [31:0] wp_y [0:1023];
  int unsigned path_len = 0;
  bit          path_rdy = 0;
  int unsigned seg_idx = 0;
  logic [31:0] prev_time = '0;
  longint unsigned k_gain, spd_max, turn_lim, adv_rad, stale_lim;

  pose_item_t pending_items[$];
  steer_cmd_t expected_cmds[$];
  int         n_errors = 0;
  int         n_results = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_phase = 0;
  int         stall_mode = 0;

  localparam longint ATAN_T [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint EXPN_T [14] = '{65440, 65344, 65153, 64772, 64018, 62535, 59671,
                                     54331, 45042, 30957, 14623, 3263, 162, 0};

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint sra(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int vector_angle(longint y, longint x);
    longint z, xs, ys, m;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? ANG_PI_Q16 : -ANG_PI_Q16;
      x = -x;
      y = -y;
    end
    for (int n = 0; n < 16; n++) begin
      xs = sra(x, n);
      ys = sra(y, n);
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_T[n];
      end else begin
        x -= ys; y += xs; z -= ATAN_T[n];
      end
    end
    m = (abs64(z) + 8) >>> 4;
    return z < 0 ? -int'(m) : int'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  // exact sign of a*b - c*d
  function automatic int cross_side(longint a, longint b, longint c, longint d);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b) - 128'(c) * 128'(d);
    return p > 0 ? 1 : (p < 0 ? -1 : 0);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GAIN_K:         k_gain = val[15:0];
      CFG_MAX_SPEED:      spd_max = val[11:0];
      CFG_RATE_LIMIT:     turn_lim = val[14:0];
      CFG_ADVANCE_RADIUS: adv_rad = val[30:0];
      CFG_STALE_LIMIT:    stale_lim = val;
      default: ;
    endcase
  endtask

  task automatic predict_step(pose_item_t it);
    int unsigned dt, s;
    longint x0, y0, x1, y1, ex, ey, steer, turn;
    longint unsigned mx, my, wp_dist, acc, aerr;
    int herr, corr, side;
    steer_cmd_t c;
    if (it.mode == MODE_LOAD) begin
      wp_x[it.slot] = it.px;
      wp_y[it.slot] = it.py;
      path_len = it.slot + 1;
      path_rdy = 1;
      return;
    end
    dt = it.tus - prev_time;
    prev_time = it.tus;
    if (!path_rdy || dt > stale_lim) return;
    s = seg_idx;
    if (s + 1 >= path_len || s + 1 >= 1024) return;
    x0 = longint'(signed'(wp_x[s]));     y0 = longint'(signed'(wp_y[s]));
    x1 = longint'(signed'(wp_x[s + 1])); y1 = longint'(signed'(wp_y[s + 1]));
    side = cross_side(x1 - x0, longint'(signed'(it.py)) - y0, y1 - y0,
                      longint'(signed'(it.px)) - x0);
    herr = vector_angle(y1 - y0, x1 - x0) - int'(signed'(it.head));
    ex = x1 - longint'(signed'(it.px));
    ey = y1 - longint'(signed'(it.py));
    mx = abs64(ex);
    my = abs64(ey);
    if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
      mx >>= 1; my >>= 1;
      wp_dist = 2 * int_sqrt(mx * mx + my * my);
    end else wp_dist = int_sqrt(mx * mx + my * my);
    corr = vector_angle(longint'(k_gain * wp_dist), 64'sd1 << 24);
    steer = herr;
    if (side > 0) steer -= corr;
    else if (side < 0) steer += corr;
    if (dt == 0) begin
      turn = steer > 0 ? longint'(turn_lim) : (steer < 0 ? -longint'(turn_lim) : 0);
    end else begin
      turn = (steer * 100000) / longint'(dt);
      if (turn > longint'(turn_lim)) turn = turn_lim;
      if (turn < -longint'(turn_lim)) turn = -longint'(turn_lim);
    end
    aerr = abs64(herr);
    if (aerr >= PI_Q12) acc = 0;
    else begin
      acc = spd_max << 16;
      for (int b = 0; b < 14; b++)
        if (aerr[b]) acc = (acc * EXPN_T[b] + 32768) >> 16;
      acc = (acc + 32768) >> 16;
    end
    c.turn = turn[15:0];
    c.spd = acc[11:0];
    c.seg = s[9:0];
    expected_cmds.push_back(c);
    if (wp_dist < adv_rad) seg_idx = (s + 1) & 10'h3FF;
  endtask

  // driver: bursts with random gaps; prediction happens on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_step(pending_items.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, pending_items[0].tus, pending_items[0].head,
                       pending_items[0].py, pending_items[0].px, pending_items[0].slot};
          in_tuser <= pending_items[0].mode;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor plus receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        steer_cmd_t got, want;
        got = out_tdata[37:0];
        n_results++;
        if (expected_cmds.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: turn %0d/%0d speed %0d/%0d segment %0d/%0d (exp/act)",
                       $signed(want.turn), $signed(got.turn), want.spd, got.spd,
                       want.seg, got.seg);
          end
        end
      end
      stall_phase++;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= (stall_phase % 5) != 0;
        2: out_tready <= ($urandom_range(0, 2) != 0);
        default: out_tready <= (stall_phase % 16) >= 9;
      endcase
      if (stall_phase % 400 == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  function automatic pose_item_t mk_load(int slot, logic [31:0] x, logic [31:0] y);
    pose_item_t it;
    it = '0;
    it.mode = MODE_LOAD; it.slot = 10'(slot); it.px = x; it.py = y;
    it.head = 15'($urandom); it.tus = $urandom;
    return it;
  endfunction

  function automatic pose_item_t mk_pose(logic [31:0] x, logic [31:0] y, int head,
                                         logic [31:0] t);
    pose_item_t it;
    it.mode = MODE_POSE; it.slot = 10'($urandom); it.px = x; it.py = y;
    it.head = head[14:0]; it.tus = t;
    return it;
  endfunction

  function automatic logic [31:0] rnd_coord(int span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  task automatic drain(int tail);
    int guard;
    guard = 0;
    while ((pending_items.size() > 0 || in_tvalid || expected_cmds.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    logic [31:0] t;
    int plen;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    k_gain = 256; spd_max = 819; turn_lim = 8192; adv_rad = 32768; stale_lim = 1000000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pose before any path, zero dt, stale, path end, extreme fields
    pending_items.push_back(mk_pose(0, 0, 0, 100));
    pending_items.push_back(mk_load(0, 0, 0));
    pending_items.push_back(mk_pose(0, 0, 0, 200));
    pending_items.push_back(mk_load(1, 32'h0001_0000, 32'h0));
    pending_items.push_back(mk_pose(32'h0000_8000, 32'h0001_0000, 0, 200));
    pending_items.push_back(mk_pose(32'h0000_8000, 32'hFFFF_0000, 12868, 20200));
    pending_items.push_back(mk_pose(32'h0, 32'h0, -12868, 5000000));
    pending_items.push_back(mk_load(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(mk_load(3, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(mk_pose(32'h8000_0000, 32'h7FFF_FFFF, 16383, 5000001));
    pending_items.push_back(mk_pose(32'h7FFF_FFFF, 32'h8000_0000, -16384, 5000002));
    pending_items.push_back(mk_pose(32'h0001_0000, 32'h0, 0, 5000002));
    pending_items.push_back(mk_pose(32'h0, 32'h0, 0, 32'hFFFF_FFFF));
    drain(150);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_GAIN_K, 32'h0000_FFFF); write_reg(CFG_MAX_SPEED, 32'h0000_0FFF);
          write_reg(CFG_RATE_LIMIT, 32'h0000_7FFF);
          write_reg(CFG_ADVANCE_RADIUS, 32'h7FFF_FFFF);
          write_reg(CFG_STALE_LIMIT, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_GAIN_K, 0); write_reg(CFG_MAX_SPEED, 0);
          write_reg(CFG_RATE_LIMIT, 0); write_reg(CFG_ADVANCE_RADIUS, 0);
          write_reg(CFG_STALE_LIMIT, 0);
        end
        default: begin
          write_reg(CFG_GAIN_K, $urandom_range(0, 2048));
          write_reg(CFG_MAX_SPEED, $urandom_range(0, 4095));
          write_reg(CFG_RATE_LIMIT, $urandom_range(0, 32767));
          write_reg(CFG_ADVANCE_RADIUS, $urandom_range(0, 32'h0004_0000));
          write_reg(CFG_STALE_LIMIT, ($urandom_range(0, 4) == 0) ? $urandom
                                                                 : $urandom_range(0, 200000));
        end
      endcase
      // fresh paths from slot 0 in each phase, so every read slot is written
      t = prev_time;
      while (pending_items.size() < 120) begin
        plen = $urandom_range(2, 12);
        if ($urandom_range(0, 99) == 0) plen = 1024;
        for (int i = 0; i < plen; i++)
          pending_items.push_back(mk_load(i, rnd_coord(32'h40000), rnd_coord(32'h40000)));
        // rewrite one slot of this path, which also shortens it unless it is the last slot
        if ($urandom_range(0, 9) == 0)
          pending_items.push_back(mk_load($urandom_range(0, plen - 1), $urandom, $urandom));
        for (int i = 0; i < 3 * 12; i++) begin
          t = t + (($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100000));
          pending_items.push_back(mk_pose(rnd_coord(32'h40000), rnd_coord(32'h40000),
                                          $signed($urandom_range(0, 32767)) - 16384, t));
        end
      end
      drain(150);
    end

    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #60000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hdl/spt_pkg.sv
hdl/spt_ram.sv
hdl/spt_cordic.sv
hdl/stanley_path_tracking_step.sv
tb/sv/tb.sv
